FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the delta decoder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a consequence in the cycle after a condition
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

FILE: hdl/pdid_pkg.sv
// ----------------------------------------------------------------------------
// pdid_pkg
// Types and codes of the pack delta instruction decoder.
// ----------------------------------------------------------------------------
package pdid_pkg;

	localparam logic [2:0] PH_SRC  = 3'd0;
	localparam logic [2:0] PH_TGT  = 3'd1;
	localparam logic [2:0] PH_CMD  = 3'd2;
	localparam logic [2:0] PH_COPY = 3'd3;
	localparam logic [2:0] PH_INS  = 3'd4;

	localparam logic [1:0] KIND_LIT  = 2'd0;
	localparam logic [1:0] KIND_COPY = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	localparam logic [2:0] CAUSE_NONE     = 3'd0;
	localparam logic [2:0] CAUSE_ZERO_CMD = 3'd1;
	localparam logic [2:0] CAUSE_INS_OVR  = 3'd2;
	localparam logic [2:0] CAUSE_COPY_OVR = 3'd3;
	localparam logic [2:0] CAUSE_TRUNC    = 3'd4;

	localparam logic [23:0] COPY_LEN_ZERO = 24'h010000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  literal;
		logic [31:0] copy_offset;
		logic [23:0] copy_length;
		logic [2:0]  error_cause;
		logic        end_of_run;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       first;
		res_t       second;
	} push_t;

endpackage

FILE: hdl/pdid_out_queue.sv
// ----------------------------------------------------------------------------
// pdid_out_queue
// Two-entry result queue; takes up to two results per cycle as room allows, sends one when ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdid_out_queue
	import pdid_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_en,
	input  push_t      push,
	output logic [1:0] free,
	output logic       head_valid,
	input  logic       head_ready,
	output res_t       head
);

	res_t       ent_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic [1:0] add;

	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rd_q];
	assign pop        = head_valid && head_ready;
	assign free       = 2'd2 - cnt_q;
	assign add        = push_en ? push.cnt : 2'd0;

	always_ff @(posedge clk) begin
		if (push_en && (push.cnt != 2'd0)) begin
			ent_q[wr_q] <= push.first;
			if (push.cnt == 2'd2) begin
				ent_q[~wr_q] <= push.second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (pop) begin
				rd_q <= ~rd_q;
			end
			wr_q  <= wr_q ^ add[0];
			cnt_q <= cnt_q - {1'b0, pop} + add;
		end
	end

	`ASSERT_AT(a_cnt_max, clk, arst_n, cnt_q <= 2'd2, "result queue over capacity")
	`ASSERT_AT(a_push_fits, clk, arst_n, push_en |-> (push.cnt <= free), "push exceeds free room")

endmodule

FILE: hdl/pdid_decode.sv
// ----------------------------------------------------------------------------
// pdid_decode
// Stream state and per-byte decode of headers, copy and insert commands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdid_decode
	import pdid_pkg::*;
#(
	parameter int SIZE_BITS = 32
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  logic [7:0] byte_in,
	input  logic       last_in,
	input  logic       commit,
	output push_t      push
);

	localparam int CW = (SIZE_BITS > 24) ? SIZE_BITS : 24;
	localparam int TW = SIZE_BITS + 7;

	logic [2:0]           phase_q,   phase_n;
	logic [SIZE_BITS-1:0] rem_q,     rem_n,   rem_upd, rem_sub;
	logic [5:0]           shift_q,   shift_n;
	logic [6:0]           pend_q,    pend_n,  pend_new, onehot;
	logic [31:0]          off_q,     off_n,   off_new, cp_off;
	logic [23:0]          len_q,     len_n,   len_new, len_src, cp_len;
	logic [6:0]           lleft_q,   lleft_n, lleft_dec;
	logic                 failed_q,  failed_n;

	logic [CW-1:0]        charge;
	logic                 over;
	logic [TW-1:0]        tgt_wide;
	logic [6:0]           shift_sum;
	logic                 shift_ok;
	logic                 do_copy;
	logic                 emit_lit;
	logic                 emit_copy;
	logic                 fin;
	logic [2:0]           cause;
	res_t                 emit_res;
	res_t                 fin_res;

	assign onehot    = pend_q & (~pend_q + 7'd1);
	assign pend_new  = pend_q & ~onehot;
	assign lleft_dec = lleft_q - 7'd1;
	assign shift_sum = {1'b0, shift_q} + 7'd7;
	assign shift_ok  = (int'(shift_q) < SIZE_BITS) && (shift_q != 6'd63);
	assign tgt_wide  = TW'(byte_in[6:0]) << shift_q;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			off_new[8*k +: 8] = off_q[8*k +: 8] | (onehot[k] ? byte_in : 8'd0);
		end
		for (int k = 0; k < 3; k++) begin
			len_new[8*k +: 8] = len_q[8*k +: 8] | (onehot[4+k] ? byte_in : 8'd0);
		end
	end

	assign len_src = (phase_q == PH_CMD) ? 24'd0 : len_new;
	assign cp_len  = (len_src == 24'd0) ? COPY_LEN_ZERO : len_src;
	assign cp_off  = (phase_q == PH_CMD) ? 32'd0 : off_new;
	assign charge  = ((phase_q == PH_CMD) && !byte_in[7]) ? CW'(byte_in) : CW'(cp_len);
	assign over    = charge > CW'(rem_q);
	assign rem_sub = rem_q - charge[SIZE_BITS-1:0];

	always_comb begin
		phase_n   = phase_q;
		rem_upd   = rem_q;
		shift_n   = shift_q;
		pend_n    = pend_q;
		off_n     = off_q;
		len_n     = len_q;
		lleft_n   = lleft_q;
		failed_n  = failed_q;
		do_copy   = 1'b0;
		emit_lit  = 1'b0;
		emit_copy = 1'b0;
		cause     = CAUSE_NONE;

		case (phase_q)
			PH_SRC: begin
				if (!byte_in[7]) begin
					phase_n = PH_TGT;
				end
			end
			PH_TGT: begin
				if (shift_ok) begin
					rem_upd = rem_q | tgt_wide[SIZE_BITS-1:0];
				end
				shift_n = (shift_sum > 7'd63) ? 6'd63 : shift_sum[5:0];
				if (!byte_in[7]) begin
					phase_n = PH_CMD;
				end
			end
			PH_CMD: begin
				if (byte_in[7]) begin
					pend_n = byte_in[6:0];
					off_n  = 32'd0;
					len_n  = 24'd0;
					if (byte_in[6:0] == 7'd0) begin
						do_copy = 1'b1;
					end else begin
						phase_n = PH_COPY;
					end
				end else if (byte_in != 8'd0) begin
					if (over) begin
						cause = CAUSE_INS_OVR;
					end else begin
						rem_upd = rem_sub;
						lleft_n = byte_in[6:0];
						phase_n = PH_INS;
					end
				end else begin
					cause = CAUSE_ZERO_CMD;
				end
			end
			PH_COPY: begin
				off_n  = off_new;
				len_n  = len_new;
				pend_n = pend_new;
				if (pend_new == 7'd0) begin
					do_copy = 1'b1;
				end
			end
			PH_INS: begin
				emit_lit = 1'b1;
				lleft_n  = lleft_dec;
				if (lleft_dec == 7'd0) begin
					phase_n = PH_CMD;
				end
			end
			default: begin
				phase_n = PH_SRC;
			end
		endcase

		if (do_copy) begin
			phase_n = PH_CMD;
			if (over) begin
				cause = CAUSE_COPY_OVR;
			end else begin
				rem_upd   = rem_sub;
				emit_copy = 1'b1;
			end
		end

		fin = (cause != CAUSE_NONE) || last_in;

		fin_res = '0;
		fin_res.end_of_run = 1'b1;
		if (cause != CAUSE_NONE) begin
			fin_res.kind        = KIND_ERR;
			fin_res.error_cause = cause;
		end else if ((phase_n == PH_CMD) && (rem_upd == '0)) begin
			fin_res.kind = KIND_DONE;
		end else begin
			fin_res.kind        = KIND_ERR;
			fin_res.error_cause = CAUSE_TRUNC;
		end

		emit_res = '0;
		if (emit_copy) begin
			emit_res.kind        = KIND_COPY;
			emit_res.copy_offset = cp_off;
			emit_res.copy_length = cp_len;
		end else begin
			emit_res.kind    = KIND_LIT;
			emit_res.literal = byte_in;
		end

		rem_n = rem_upd;
		if ((cause != CAUSE_NONE) && !last_in) begin
			failed_n = 1'b1;
		end

		push.first  = (emit_lit || emit_copy) ? emit_res : fin_res;
		push.second = fin_res;
		push.cnt    = 2'({1'b0, emit_lit || emit_copy} + {1'b0, fin});

		if (failed_q) begin
			phase_n  = phase_q;
			rem_n    = rem_q;
			shift_n  = shift_q;
			pend_n   = pend_q;
			off_n    = off_q;
			len_n    = len_q;
			lleft_n  = lleft_q;
			failed_n = 1'b1;
			push.cnt = 2'd0;
		end

		if (last_in) begin
			phase_n  = PH_SRC;
			rem_n    = '0;
			shift_n  = 6'd0;
			pend_n   = 7'd0;
			off_n    = 32'd0;
			len_n    = 24'd0;
			lleft_n  = 7'd0;
			failed_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SRC;
			rem_q    <= '0;
			shift_q  <= 6'd0;
			pend_q   <= 7'd0;
			off_q    <= 32'd0;
			len_q    <= 24'd0;
			lleft_q  <= 7'd0;
			failed_q <= 1'b0;
		end else if (commit) begin
			phase_q  <= phase_n;
			rem_q    <= rem_n;
			shift_q  <= shift_n;
			pend_q   <= pend_n;
			off_q    <= off_n;
			len_q    <= len_n;
			lleft_q  <= lleft_n;
			failed_q <= failed_n;
		end
	end

	`ASSERT_AT(a_failed_quiet, clk, arst_n, (failed_q && valid) |-> (push.cnt == 2'd0), "result after error")
	`ASSERT_NEXT(a_last_clears, clk, arst_n, (commit && last_in), ((phase_q == PH_SRC) && !failed_q), "stream end did not clear")

endmodule

FILE: hdl/pack_delta_instruction_decoder_unit.sv
// ----------------------------------------------------------------------------
// pack_delta_instruction_decoder_unit
// Decodes a pack delta byte stream into literal, copy and end results.
//
//   channel  dir  fields
//   s_*      in   tdata: delta_byte[7:0]; tlast: last_byte
//   m_*      out  tdata: literal[7:0] copy_offset[39:8] copy_length[63:40]
//                        error_cause[66:64]; tuser: kind; tlast: end_of_run
//
// One byte per cycle while each byte yields at most one result and the output is ready.
// A byte with two results needs an empty queue, so it and the byte after it
// may each wait for the queue to drain.
// A taken byte is held in the input register, then decoded into the two-entry
// result queue, whose head is offered; a full queue holds it in the register.
// A result waiting at the output does not stop the next byte unless
// the queue lacks room for all results of that byte.
// Reset returns the stream state to the source size header.
// ----------------------------------------------------------------------------
module pack_delta_instruction_decoder_unit
	import pdid_pkg::*;
#(
	parameter int SIZE_BITS = 32
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // delta_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // literal, copy_offset, copy_length, error_cause
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;
	logic [1:0] free;
	push_t      push;
	res_t       head;

	assign adv      = valid_s1 && (push.cnt <= free);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	pdid_decode #(
		.SIZE_BITS(SIZE_BITS)
	) u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (valid_s1),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.commit  (adv),
		.push    (push)
	);

	pdid_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_en    (adv),
		.push       (push),
		.free       (free),
		.head_valid (m_tvalid),
		.head_ready (m_tready),
		.head       (head)
	);

	assign m_tdata = {5'd0, head.error_cause, head.copy_length, head.copy_offset, head.literal};
	assign m_tuser = head.kind;
	assign m_tlast = head.end_of_run;

endmodule
